/* src/saa_pkg.sv */
// ----------------------------------------------------------------------------
// Skyline atlas allocator package
// Shared widths, codes and the command and status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package saa_pkg;

  localparam int DIM_W      = 12;
  localparam int LIMIT_W    = 8;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 11;
  localparam int PAGE_W     = 8;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT = 2'd1;

  localparam logic [DIM_W-1:0]   ATLAS_SIZE_RST = 12'd1024;
  localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RST = 8'd64;

  localparam logic OP_CLOSE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_LARGE = 2'd1,
    STATUS_LIMIT     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SWEEP_CLEAR = 2'd0,
    SWEEP_PASS1 = 2'd1,
    SWEEP_PASS2 = 2'd2,
    SWEEP_RAISE = 2'd3
  } sweep_e;

  typedef struct packed {
    logic    load;
    logic    prep;
    logic    go;
    sweep_e  mode;
    logic    inc_page;
    logic    finish;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic limit;
    logic is_close;
    logic w_zero;
    logic w_big;
    logic fits;
  } dp_sts_t;

endpackage

/* src/skyline_atlas_allocator_unit.sv */
// ----------------------------------------------------------------------------
// Skyline atlas allocator
// Packs rectangles into square atlas pages with a per-column height skyline.
// ----------------------------------------------------------------------------
//  Channel  | Signals                                   | Handshake
//  ---------+-------------------------------------------+---------------------------
//  command  | op_i, width_i, height_i                   | start & !busy
//  result   | col_o, row_o, page_o, status_o            | res_strobe_o, one cycle
//  config   | cfg_index_i, cfg_data_i                   | cfg_valid_i & cfg_ready_o
//
// After reset the column-height memory is swept to zero with busy high;
// configuration writes are taken during that time.
// An allocate runs two sweeps over the single-ported column-height memory
// and then the raise writes. A close, or a failed first fit, adds a clear
// sweep; a retry then repeats the scan.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module skyline_atlas_allocator_unit #(
  parameter int MAX_ATLAS_SIZE = 2048
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              op_i,
  input  logic [saa_pkg::DIM_W-1:0]         width_i,
  input  logic [saa_pkg::DIM_W-1:0]         height_i,
  output logic                              res_strobe_o,
  output logic [saa_pkg::COL_W-1:0]         col_o,
  output logic [saa_pkg::ROW_W-1:0]         row_o,
  output logic [saa_pkg::PAGE_W-1:0]        page_o,
  output logic [saa_pkg::STATUS_W-1:0]      status_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [saa_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [saa_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import saa_pkg::*;

  logic [DIM_W-1:0]   atlas_size_q;
  logic [LIMIT_W-1:0] page_limit_q;
  dp_cmd_t            cmd;
  dp_sts_t            sts;

  assign cfg_ready_o = 1'b1;

  // Writes to indexes past the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_size_q <= ATLAS_SIZE_RST;
      page_limit_q <= PAGE_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ATLAS_SIZE: atlas_size_q <= DIM_W'(cfg_data_i);
        CFG_PAGE_LIMIT: page_limit_q <= LIMIT_W'(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  saa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  saa_dpath #(
    .MAX_ATLAS_SIZE (MAX_ATLAS_SIZE)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .op_i         (op_i),
    .width_i      (width_i),
    .height_i     (height_i),
    .atlas_size_i (atlas_size_q),
    .page_limit_i (page_limit_q),
    .res_strobe_o (res_strobe_o),
    .col_o        (col_o),
    .row_o        (row_o),
    .page_o       (page_o),
    .status_o     (status_o)
  );

endmodule

/* src/saa_dpath.sv */
// ----------------------------------------------------------------------------
// Skyline atlas allocator datapath
// Column-height memory, block prefix/suffix maximum scan, best window search,
// skyline raise and clear sweeps, page counter and result registers.
// ----------------------------------------------------------------------------
module saa_dpath #(
  parameter int MAX_ATLAS_SIZE = 2048
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  saa_pkg::dp_cmd_t               cmd_i,
  output saa_pkg::dp_sts_t               sts_o,
  input  logic                           op_i,
  input  logic [saa_pkg::DIM_W-1:0]      width_i,
  input  logic [saa_pkg::DIM_W-1:0]      height_i,
  input  logic [saa_pkg::DIM_W-1:0]      atlas_size_i,
  input  logic [saa_pkg::LIMIT_W-1:0]    page_limit_i,
  output logic                           res_strobe_o,
  output logic [saa_pkg::COL_W-1:0]      col_o,
  output logic [saa_pkg::ROW_W-1:0]      row_o,
  output logic [saa_pkg::PAGE_W-1:0]     page_o,
  output logic [saa_pkg::STATUS_W-1:0]   status_o
);
  import saa_pkg::*;

  localparam int HW = $clog2(MAX_ATLAS_SIZE + 1);
  localparam int AW = $clog2(MAX_ATLAS_SIZE);
  localparam int CW = ((HW > DIM_W) ? HW : DIM_W) + 1;
  localparam logic [CW-1:0] MAX_C     = CW'(MAX_ATLAS_SIZE);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ATLAS_SIZE - 1);

  // Item and derived scan bounds.
  logic              op_q;
  logic [DIM_W-1:0]  w_q, h_q;
  logic [HW-1:0]     size_q;
  logic [AW-1:0]     last_q, lastwin_q, wm1_q;
  logic [AW-1:0]     off_t_q, off_t_d;

  // Sweep engine.
  logic              run_q;
  sweep_e            mode_q;
  logic [AW-1:0]     cnt_q, end_q, off_q;
  logic [AW-1:0]     cnt_init, end_init;
  logic              last_hit;

  // Read stage.
  logic              s1_v_q, s1_last_q;
  logic [AW-1:0]     s1_k_q, s1_off_q;
  logic [HW-1:0]     hrd_q, ard_q;
  logic [HW-1:0]     prefix_q, suffix_q;
  logic [HW-1:0]     prefix_new, suffix_new, wmax;
  logic              take;

  logic [HW-1:0]     best_q;
  logic [AW-1:0]     pos_q;
  logic [PAGE_W-1:0] page_q;

  logic [CW-1:0]     w_c, h_c, size_c, best_c, reach_c;
  logic [HW-1:0]     fill;
  logic              hmem_we;
  logic [HW-1:0]     hmem_wd;
  logic [AW-1:0]     amem_ra;

  logic [HW-1:0]     hmem [MAX_ATLAS_SIZE];
  logic [HW-1:0]     amem [MAX_ATLAS_SIZE];

  logic                strobe_q;
  logic [COL_W-1:0]    col_q;
  logic [ROW_W-1:0]    row_q;
  logic [PAGE_W-1:0]   page_out_q;
  logic [STATUS_W-1:0] status_q;

  assign w_c     = CW'(w_q);
  assign h_c     = CW'(h_q);
  assign size_c  = CW'(size_q);
  assign best_c  = CW'(best_q);
  assign reach_c = best_c + h_c;
  assign fill    = HW'(reach_c);

  assign last_hit = (cnt_q == end_q);

  assign sts_o.done     = (run_q && last_hit &&
                           (mode_q == SWEEP_CLEAR || mode_q == SWEEP_RAISE)) ||
                          (s1_v_q && s1_last_q);
  assign sts_o.limit    = (page_q >= page_limit_i);
  assign sts_o.is_close = (op_q == OP_CLOSE);
  assign sts_o.w_zero   = (w_q == '0);
  assign sts_o.w_big    = (w_c >= size_c);
  assign sts_o.fits     = (best_c < size_c) && (reach_c <= size_c);

  always_comb begin
    case (cmd_i.mode)
      SWEEP_CLEAR: begin
        cnt_init = '0;
        end_init = LAST_ADDR;
      end
      SWEEP_PASS1: begin
        cnt_init = '0;
        end_init = last_q;
      end
      SWEEP_PASS2: begin
        cnt_init = last_q;
        end_init = '0;
      end
      SWEEP_RAISE: begin
        cnt_init = pos_q;
        end_init = pos_q + wm1_q;
      end
      default: begin
        cnt_init = '0;
        end_init = LAST_ADDR;
      end
    endcase
  end

  // The first pass ends in the same cycle that starts the second one, so the
  // block offset of the last column is forwarded.
  assign off_t_d = (s1_v_q && s1_last_q && mode_q == SWEEP_PASS1) ? s1_off_q : off_t_q;

  assign hmem_we = run_q && (mode_q == SWEEP_CLEAR || mode_q == SWEEP_RAISE);
  assign hmem_wd = (mode_q == SWEEP_CLEAR) ? '0 : fill;
  assign amem_ra = cnt_q + wm1_q;

  // Blocks of width columns: a window spans the tail of one block and the
  // head of the next, so its maximum is max(suffix, prefix).
  assign prefix_new = (s1_off_q == '0 || hrd_q > prefix_q) ? hrd_q : prefix_q;
  assign suffix_new = (s1_k_q == last_q || s1_off_q == wm1_q || hrd_q > suffix_q) ?
                      hrd_q : suffix_q;
  assign wmax       = (ard_q > suffix_new) ? ard_q : suffix_new;
  // Descending scan: ties go to the lower left column.
  assign take       = s1_v_q && (mode_q == SWEEP_PASS2) && (s1_k_q <= lastwin_q) &&
                      (wmax < size_q) && (wmax <= best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      mode_q   <= SWEEP_CLEAR;
      s1_v_q   <= 1'b0;
      page_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      if (cmd_i.go) begin
        run_q  <= 1'b1;
        mode_q <= cmd_i.mode;
      end else if (run_q && last_hit) begin
        run_q <= 1'b0;
      end
      s1_v_q   <= run_q && (mode_q == SWEEP_PASS1 || mode_q == SWEEP_PASS2);
      if (cmd_i.inc_page) begin
        page_q <= page_q + 1'b1;
      end
      strobe_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      w_q    <= width_i;
      h_q    <= height_i;
      size_q <= (CW'(atlas_size_i) > MAX_C) ? HW'(MAX_ATLAS_SIZE) : HW'(atlas_size_i);
    end
    if (cmd_i.prep) begin
      last_q    <= AW'(size_c - CW'(2));
      lastwin_q <= AW'(size_c - w_c - CW'(1));
      wm1_q     <= AW'(w_c - CW'(1));
      best_q    <= sts_o.w_zero ? '0 : size_q;
      pos_q     <= sts_o.w_zero ? AW'(size_c - CW'(1)) : '0;
    end else if (take) begin
      best_q <= wmax;
      pos_q  <= s1_k_q;
    end

    if (cmd_i.go) begin
      cnt_q <= cnt_init;
      end_q <= end_init;
      off_q <= (cmd_i.mode == SWEEP_PASS2) ? off_t_d : '0;
    end else if (run_q) begin
      if (!last_hit) begin
        cnt_q <= (mode_q == SWEEP_PASS2) ? cnt_q - 1'b1 : cnt_q + 1'b1;
      end
      if (mode_q == SWEEP_PASS2) begin
        off_q <= (off_q == '0) ? wm1_q : off_q - 1'b1;
      end else begin
        off_q <= (off_q == wm1_q) ? '0 : off_q + 1'b1;
      end
    end
    off_t_q <= off_t_d;

    s1_last_q <= last_hit;
    s1_k_q    <= cnt_q;
    s1_off_q  <= off_q;

    if (s1_v_q && mode_q == SWEEP_PASS1) begin
      prefix_q <= prefix_new;
    end
    if (s1_v_q && mode_q == SWEEP_PASS2) begin
      suffix_q <= suffix_new;
    end

    if (cmd_i.finish) begin
      if (cmd_i.status == STATUS_OK && op_q != OP_CLOSE) begin
        col_q <= COL_W'(pos_q);
        row_q <= ROW_W'(best_q);
      end else begin
        col_q <= '0;
        row_q <= '0;
      end
      page_out_q <= page_q;
      status_q   <= cmd_i.status;
    end
  end

  // Column heights and block prefix maxima, one write and one read port each.
  always_ff @(posedge clk_i) begin
    if (hmem_we) begin
      hmem[cnt_q] <= hmem_wd;
    end
    hrd_q <= hmem[cnt_q];
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q && mode_q == SWEEP_PASS1) begin
      amem[s1_k_q] <= prefix_new;
    end
    ard_q <= amem[amem_ra];
  end

  assign res_strobe_o = strobe_q;
  assign col_o        = col_q;
  assign row_o        = row_q;
  assign page_o       = page_out_q;
  assign status_o     = status_q;

endmodule

/* src/saa_ctrl.sv */
// ----------------------------------------------------------------------------
// Skyline atlas allocator controller
// Sequences clear, scan, raise and retry for each item and reports busy.
// ----------------------------------------------------------------------------
module saa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  saa_pkg::dp_sts_t   sts_i,
  output saa_pkg::dp_cmd_t   cmd_o,
  output logic               busy
);
  import saa_pkg::*;

  localparam logic [3:0] S_INIT       = 4'd0;
  localparam logic [3:0] S_INIT_WAIT  = 4'd1;
  localparam logic [3:0] S_IDLE       = 4'd2;
  localparam logic [3:0] S_ENTRY      = 4'd3;
  localparam logic [3:0] S_CLOSE_WAIT = 4'd4;
  localparam logic [3:0] S_PREP       = 4'd5;
  localparam logic [3:0] S_TRY        = 4'd6;
  localparam logic [3:0] S_P1_WAIT    = 4'd7;
  localparam logic [3:0] S_P2_WAIT    = 4'd8;
  localparam logic [3:0] S_CHECK      = 4'd9;
  localparam logic [3:0] S_RAISE_WAIT = 4'd10;
  localparam logic [3:0] S_RETRY_WAIT = 4'd11;

  logic [3:0] state_q, state_d;
  logic       retry_q, retry_d;

  always_comb begin
    state_d = state_q;
    retry_d = retry_q;
    cmd_o   = '0;
    cmd_o.mode   = SWEEP_CLEAR;
    cmd_o.status = STATUS_OK;
    case (state_q)
      S_INIT: begin
        cmd_o.go = 1'b1;
        state_d  = S_INIT_WAIT;
      end
      S_INIT_WAIT: begin
        if (sts_i.done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          retry_d    = 1'b0;
          state_d    = S_ENTRY;
        end
      end
      S_ENTRY: begin
        if (sts_i.limit) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = STATUS_LIMIT;
          state_d      = S_IDLE;
        end else if (sts_i.is_close) begin
          cmd_o.inc_page = 1'b1;
          cmd_o.go       = 1'b1;
          state_d        = S_CLOSE_WAIT;
        end else begin
          state_d = S_PREP;
        end
      end
      S_CLOSE_WAIT: begin
        if (sts_i.done) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_TRY;
      end
      S_TRY: begin
        // A zero width or a width at the page edge needs no scan.
        if (sts_i.w_zero || sts_i.w_big) begin
          state_d = S_CHECK;
        end else begin
          cmd_o.go   = 1'b1;
          cmd_o.mode = SWEEP_PASS1;
          state_d    = S_P1_WAIT;
        end
      end
      S_P1_WAIT: begin
        if (sts_i.done) begin
          cmd_o.go   = 1'b1;
          cmd_o.mode = SWEEP_PASS2;
          state_d    = S_P2_WAIT;
        end
      end
      S_P2_WAIT: begin
        if (sts_i.done) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.fits) begin
          if (sts_i.w_zero) begin
            cmd_o.finish = 1'b1;
            state_d      = S_IDLE;
          end else begin
            cmd_o.go   = 1'b1;
            cmd_o.mode = SWEEP_RAISE;
            state_d    = S_RAISE_WAIT;
          end
        end else if (!retry_q) begin
          retry_d        = 1'b1;
          cmd_o.inc_page = 1'b1;
          cmd_o.go       = 1'b1;
          state_d        = S_RETRY_WAIT;
        end else begin
          cmd_o.finish = 1'b1;
          cmd_o.status = STATUS_TOO_LARGE;
          state_d      = S_IDLE;
        end
      end
      S_RAISE_WAIT: begin
        if (sts_i.done) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_RETRY_WAIT: begin
        if (sts_i.done) begin
          if (sts_i.limit) begin
            cmd_o.finish = 1'b1;
            cmd_o.status = STATUS_LIMIT;
            state_d      = S_IDLE;
          end else begin
            state_d = S_PREP;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      retry_q <= 1'b0;
    end else begin
      state_q <= state_d;
      retry_q <= retry_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule
